### sv/tnf_pkg.sv
// Package for the tag nesting framer.
// Holds the buffer and depth limits, the delimiter characters and the tag kind codes.
// No dependencies.
package tnf_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int MAX_DEPTH = 255;

    // The depth register is eight bits wide, so the ceiling never exceeds 255.
    localparam int DEPTH_CEIL_INT = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;
    localparam logic [7:0] DEPTH_CEIL = 8'(DEPTH_CEIL_INT);

    // The pending length never holds BUF_BYTES itself: reaching it resets the framer.
    localparam int LEN_W = (BUF_BYTES > 2) ? $clog2(BUF_BYTES) : 1;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(BUF_BYTES - 1);

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_SELF  = 2'd2
    } t_tag_kind;

endpackage

### sv/tag_nesting_framer_top.sv
// Top level of the tag nesting framer.
// Splits a byte stream into tags and tracks their nesting depth; uses tnf_pkg.
// Contains the tag state registers and the output result register.
//
// The framer accepts one byte per clock and returns exactly one result per byte,
// in the cycle after its transfer. All classification happens in one pass of
// logic between the tag state registers and the result register, so the rate is
// one byte per cycle as long as the downstream side does not stall. The result
// register is refilled in the same cycle it is emptied, so a stall on the output
// reaches the input only while the result register holds a result not yet taken.
module tag_nesting_framer_top
    import tnf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_content_valid,
    output logic [7:0] o_content_byte,
    output logic       o_tag_end,
    output logic [1:0] o_tag_kind,
    output logic [7:0] o_depth_now,
    output logic       o_group_complete,
    output logic       o_tag_dropped,
    output logic       o_overflow
);

    logic             r_inside;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_first;
    logic [7:0]       r_prev;
    logic [7:0]       r_depth;

    logic             n_inside;
    logic [LEN_W-1:0] n_len;
    logic [7:0]       n_first;
    logic [7:0]       n_prev;
    logic [7:0]       n_depth;

    logic             r_valid;
    logic             r_content_valid;
    logic [7:0]       r_content_byte;
    logic             r_tag_end;
    t_tag_kind        r_tag_kind;
    logic             r_group_complete;
    logic             r_tag_dropped;
    logic             r_overflow;

    logic             n_content_valid;
    logic [7:0]       n_content_byte;
    logic             n_tag_end;
    t_tag_kind        n_tag_kind;
    logic             n_group_complete;
    logic             n_tag_dropped;
    logic             n_overflow;

    logic             in_xfer;

    assign o_stall = r_valid & i_stall;
    assign in_xfer = i_valid & ~o_stall;

    always_comb begin
        n_inside         = r_inside;
        n_len            = r_len;
        n_first          = r_first;
        n_prev           = r_prev;
        n_depth          = r_depth;
        n_content_valid  = 1'b0;
        n_content_byte   = 8'd0;
        n_tag_end        = 1'b0;
        n_tag_kind       = KIND_OPEN;
        n_group_complete = 1'b0;
        n_tag_dropped    = 1'b0;
        n_overflow       = 1'b0;

        if (!r_inside) begin
            if (i_data_byte == CH_OPEN) begin
                n_inside = 1'b1;
                n_len    = '0;
            end
        end else if (i_data_byte == CH_CLOSE) begin
            n_inside = 1'b0;
            n_len    = '0;
            if (r_len != '0) begin
                n_tag_end = 1'b1;
                if (r_first == CH_SLASH) begin
                    n_tag_kind = KIND_CLOSE;
                    if (r_depth == 8'd0) begin
                        n_tag_dropped = 1'b1;
                    end else begin
                        n_depth          = r_depth - 8'd1;
                        n_group_complete = (r_depth == 8'd1);
                    end
                end else if (r_prev == CH_SLASH) begin
                    n_tag_kind       = KIND_SELF;
                    n_group_complete = (r_depth == 8'd0);
                end else begin
                    n_tag_kind = KIND_OPEN;
                    if (r_depth < DEPTH_CEIL) begin
                        n_depth = r_depth + 8'd1;
                    end
                end
            end
        end else begin
            n_content_valid = 1'b1;
            n_content_byte  = i_data_byte;
            if (r_len == '0) begin
                n_first = i_data_byte;
            end
            n_prev = i_data_byte;
            if (r_len == LEN_LAST) begin
                n_overflow = 1'b1;
                n_inside   = 1'b0;
                n_len      = '0;
                n_first    = 8'd0;
                n_prev     = 8'd0;
                n_depth    = 8'd0;
            end else begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
            r_first  <= 8'd0;
            r_prev   <= 8'd0;
            r_depth  <= 8'd0;
        end else if (in_xfer) begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_first  <= n_first;
            r_prev   <= n_prev;
            r_depth  <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_xfer) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_content_valid  <= n_content_valid;
            r_content_byte   <= n_content_byte;
            r_tag_end        <= n_tag_end;
            r_tag_kind       <= n_tag_kind;
            r_group_complete <= n_group_complete;
            r_tag_dropped    <= n_tag_dropped;
            r_overflow       <= n_overflow;
        end
    end

    assign o_valid          = r_valid;
    assign o_content_valid  = r_content_valid;
    assign o_content_byte   = r_content_byte;
    assign o_tag_end        = r_tag_end;
    assign o_tag_kind       = r_tag_kind;
    assign o_depth_now      = r_depth;
    assign o_group_complete = r_group_complete;
    assign o_tag_dropped    = r_tag_dropped;
    assign o_overflow       = r_overflow;

endmodule

### sv/tnf_checker.sv
// Port-level checker for the tag nesting framer, bound to tag_nesting_framer_top.
// Checks output holding under stall and consistency of the result flags; uses tnf_pkg.
module tnf_checker
    import tnf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_content_valid,
    input logic [7:0] o_content_byte,
    input logic       o_tag_end,
    input logic [1:0] o_tag_kind,
    input logic [7:0] o_depth_now,
    input logic       o_group_complete,
    input logic       o_tag_dropped,
    input logic       o_overflow
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_content_byte) && $stable(o_depth_now)
            && $stable(o_tag_kind) && $stable(o_tag_end))
        else $error("Stalled result changed.");

    a_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag_dropped |-> o_tag_end && o_tag_kind == KIND_CLOSE
            && o_depth_now == 8'd0 && !o_group_complete)
        else $error("Dropped tag result is inconsistent.");

    a_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_group_complete |-> o_tag_end && o_depth_now == 8'd0
            && o_tag_kind != KIND_OPEN)
        else $error("Group completion without a closing tag at depth zero.");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_content_valid && !o_tag_end && o_depth_now == 8'd0)
        else $error("Overflow result is inconsistent.");

endmodule

bind tag_nesting_framer_top tnf_checker u_tnf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_content_valid  (o_content_valid),
    .o_content_byte   (o_content_byte),
    .o_tag_end        (o_tag_end),
    .o_tag_kind       (o_tag_kind),
    .o_depth_now      (o_depth_now),
    .o_group_complete (o_group_complete),
    .o_tag_dropped    (o_tag_dropped),
    .o_overflow       (o_overflow)
);
